// ===== sv/fts_pkg.sv =====
// Shared constants, codes and types for the second-chance frame table.
// No dependencies; used by the channel interfaces and every module.
package fts_pkg;

   localparam int FRAMES      = 16;
   localparam int FRAME_BITS  = $clog2(FRAMES);
   localparam int COUNT_BITS  = $clog2(FRAMES + 1);
   localparam int PAGE_BITS   = 16;
   localparam int OP_BITS     = 2;
   localparam int FNUM_BITS   = 4;
   localparam int STATUS_BITS = 2;
   localparam int ACTION_BITS = 2;
   localparam int CMP_BITS    = (PAGE_BITS > FRAME_BITS) ? PAGE_BITS : FRAME_BITS;

   // per-frame flag bits
   localparam int FLAG_BITS  = 4;
   localparam int FLAG_ACC   = 0;
   localparam int FLAG_DIRTY = 1;
   localparam int FLAG_MAP   = 2;
   localparam int FLAG_SWAP  = 3;

   // configuration port
   localparam int CFG_BITS       = 5;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_INDEX_BITS = CSR_ADDR_BITS - 2;
   localparam int CSR_DATA_BITS  = 32;
   localparam logic [CFG_BITS-1:0]       CFG_FRAME_COUNT_RESET = CFG_BITS'(16);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IDX_USER_FRAME_COUNT = '0;

   typedef enum logic [OP_BITS-1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_FIND  = 2'd2,
      OP_TOUCH = 2'd3
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_NO_FRAME  = 2'd2
   } status_type;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_DROP      = 2'd0,
      ACT_WRITEBACK = 2'd1,
      ACT_SWAP      = 2'd2
   } action_type;

   // update/read request from the sequencer to the frame table
   typedef struct packed {
      logic                  clr_acc;
      logic                  mark;
      logic                  mark_dirty;
      logic                  remove;
      logic                  append;
      logic [FRAME_BITS-1:0] pos;
      logic [FRAME_BITS-1:0] frame;
      logic [PAGE_BITS-1:0]  page;
      logic [FLAG_BITS-1:0]  flags;
   } tbl_cmd_type;

   // table contents at the requested age position and frame
   typedef struct packed {
      logic [FRAME_BITS-1:0] age_frame;
      logic [PAGE_BITS-1:0]  page;
      logic [FLAG_BITS-1:0]  flags;
      logic                  free;
      logic [COUNT_BITS-1:0] count;
   } tbl_view_type;

endpackage

// ===== sv/fts_channels.sv =====
// Valid/ready channel interfaces for requests and responses of the frame table.
// Depends on fts_pkg for field widths.
interface fts_req_if;
   logic                              valid;
   logic                              ready;
   logic [fts_pkg::OP_BITS-1:0]       op;
   logic [fts_pkg::PAGE_BITS-1:0]     page_id;
   logic [fts_pkg::FNUM_BITS-1:0]     frame_number;
   logic                              is_mapped_file;
   logic                              was_swapped;
   logic                              is_write;

   modport source (output valid, op, page_id, frame_number, is_mapped_file, was_swapped,
                   is_write, input ready);
   modport sink   (input valid, op, page_id, frame_number, is_mapped_file, was_swapped,
                   is_write, output ready);
endinterface

interface fts_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [fts_pkg::STATUS_BITS-1:0]   status;
   logic [fts_pkg::FNUM_BITS-1:0]     result_frame;
   logic                              evicted;
   logic [fts_pkg::PAGE_BITS-1:0]     evicted_page;
   logic [fts_pkg::ACTION_BITS-1:0]   evict_action;

   modport source (output valid, status, result_frame, evicted, evicted_page, evict_action,
                   input ready);
   modport sink   (input valid, status, result_frame, evicted, evicted_page, evict_action,
                   output ready);
endinterface

// ===== sv/frame_table_second_chance.sv =====
// Physical frame table with second-chance eviction.
// Channels: req_ch (valid/ready) carries op, page_id, frame_number, is_mapped_file,
// was_swapped and is_write; rsp_ch (valid/ready) returns one response per transaction:
// status, result_frame, evicted, evicted_page, evict_action.
// csr_* is an APB-style port; user_frame_count lives at byte address 0.
// One transaction at a time; req_ch.ready is high only while the sequencer is idle.
// Steps: find/free/touch are accepted, walk the age list entry by entry (at most
// FRAMES entries examined) and respond. Allocate checks the pool frames in order up
// to the lowest free one; when none is free it sees the end of the pool and scans the
// age list for a victim (at most resident count + 1 entries), or returns no-frame if
// nothing is resident. It then appends the new page and responds.
// The single cursor steps the pool and the age list.
// A finished response sits in an output register; a new transaction is accepted
// while it waits, and the next response holds in the sequencer until rsp_ch drains.
// Reset: all frames free, nothing resident, all flags clear, user_frame_count = 16;
// the block is ready the cycle after reset drops.
// Depends on fts_pkg, fts_channels, fts_table and fts_ctrl.
module frame_table_second_chance (
   input  logic                              clock,
   input  logic                              reset,
   fts_req_if.sink                           req_ch,
   fts_rsp_if.source                         rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [fts_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [fts_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [fts_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);

   logic [fts_pkg::CFG_BITS-1:0] frame_count_ff, frame_count_in;
   logic                         csr_hit;
   fts_pkg::tbl_cmd_type         cmd;
   fts_pkg::tbl_view_type        view;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[fts_pkg::CSR_ADDR_BITS-1:2] ==
                        fts_pkg::CSR_IDX_USER_FRAME_COUNT);
   assign csr_prdata = csr_hit ? fts_pkg::CSR_DATA_BITS'(frame_count_ff) : '0;

   always_comb begin
      frame_count_in = frame_count_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         frame_count_in = csr_pwdata[fts_pkg::CFG_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= fts_pkg::CFG_FRAME_COUNT_RESET;
      end else begin
         frame_count_ff <= frame_count_in;
      end
   end

   fts_table u_table (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .view  (view)
   );

   fts_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .user_frame_count (frame_count_ff),
      .cmd              (cmd),
      .view             (view)
   );

endmodule

// ===== sv/fts_table.sv =====
// Frame table storage: free map, age list, page handles and flags per frame.
// Depends on fts_pkg; driven one command per cycle by fts_ctrl.
module fts_table (
   input  logic                 clock,
   input  logic                 reset,
   input  fts_pkg::tbl_cmd_type cmd,
   output fts_pkg::tbl_view_type view
);

   logic [fts_pkg::FRAMES-1:0]     free_ff, free_in;
   logic [fts_pkg::FLAG_BITS-1:0]  flags_ff [fts_pkg::FRAMES];
   logic [fts_pkg::FLAG_BITS-1:0]  flags_in [fts_pkg::FRAMES];
   logic [fts_pkg::FRAME_BITS-1:0] age_ff   [fts_pkg::FRAMES];
   logic [fts_pkg::FRAME_BITS-1:0] age_in   [fts_pkg::FRAMES];
   logic [fts_pkg::PAGE_BITS-1:0]  page_ff  [fts_pkg::FRAMES];
   logic [fts_pkg::PAGE_BITS-1:0]  page_in  [fts_pkg::FRAMES];
   logic [fts_pkg::COUNT_BITS-1:0] count_ff, count_in;

   assign view.age_frame = age_ff[cmd.pos];
   assign view.page      = page_ff[cmd.frame];
   assign view.flags     = flags_ff[cmd.frame];
   assign view.free      = free_ff[cmd.frame];
   assign view.count     = count_ff;

   always_comb begin
      free_in  = free_ff;
      flags_in = flags_ff;
      age_in   = age_ff;
      page_in  = page_ff;
      count_in = count_ff;
      if (cmd.clr_acc) begin
         flags_in[cmd.frame][fts_pkg::FLAG_ACC] = 1'b0;
      end
      if (cmd.mark) begin
         flags_in[cmd.frame][fts_pkg::FLAG_ACC] = 1'b1;
         if (cmd.mark_dirty) begin
            flags_in[cmd.frame][fts_pkg::FLAG_DIRTY] = 1'b1;
         end
      end
      if (cmd.remove) begin
         for (int i = 0; i < fts_pkg::FRAMES - 1; i++) begin
            if (fts_pkg::FRAME_BITS'(i) >= cmd.pos) begin
               age_in[i] = age_ff[i + 1];
            end
         end
         count_in             = count_ff - 1'b1;
         free_in[cmd.frame]   = 1'b1;
         flags_in[cmd.frame]  = '0;
      end
      if (cmd.append) begin
         age_in[count_ff[fts_pkg::FRAME_BITS-1:0]] = cmd.frame;
         count_in             = count_ff + 1'b1;
         free_in[cmd.frame]   = 1'b0;
         page_in[cmd.frame]   = cmd.page;
         flags_in[cmd.frame]  = cmd.flags;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff  <= '1;
         count_ff <= '0;
         for (int i = 0; i < fts_pkg::FRAMES; i++) begin
            flags_ff[i] <= '0;
         end
      end else begin
         free_ff  <= free_in;
         count_ff <= count_in;
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      age_ff  <= age_in;
      page_ff <= page_in;
   end

endmodule

// ===== sv/fts_ctrl.sv =====
// Sequencer of the frame table: one cursor, one incrementer and one comparator
// stepped over the pool and the age list. Depends on fts_pkg, fts_channels, fts_table.
module fts_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   fts_req_if.sink                       req_ch,
   fts_rsp_if.source                     rsp_ch,
   input  logic [fts_pkg::CFG_BITS-1:0]  user_frame_count,
   output fts_pkg::tbl_cmd_type          cmd,
   input  fts_pkg::tbl_view_type         view
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_POOL   = 6'b000010,
      S_EVICT  = 6'b000100,
      S_LIST   = 6'b001000,
      S_APPEND = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   state_type                      state_ff, state_in;
   fts_pkg::op_type                op_ff, op_in;
   logic [fts_pkg::PAGE_BITS-1:0]  page_ff, page_in;
   logic [fts_pkg::FNUM_BITS-1:0]  fnum_ff, fnum_in;
   logic                           mapped_ff, mapped_in;
   logic                           swapped_ff, swapped_in;
   logic                           write_ff, write_in;
   logic [fts_pkg::COUNT_BITS-1:0] cur_ff, cur_in;

   fts_pkg::status_type            res_status_ff, res_status_in;
   logic [fts_pkg::FRAME_BITS-1:0] res_frame_ff, res_frame_in;
   logic                           res_evicted_ff, res_evicted_in;
   logic [fts_pkg::PAGE_BITS-1:0]  res_evpage_ff, res_evpage_in;
   fts_pkg::action_type            res_action_ff, res_action_in;

   logic                           out_valid_ff, out_valid_in;
   fts_pkg::status_type            out_status_ff, out_status_in;
   logic [fts_pkg::FRAME_BITS-1:0] out_frame_ff, out_frame_in;
   logic                           out_evicted_ff, out_evicted_in;
   logic [fts_pkg::PAGE_BITS-1:0]  out_evpage_ff, out_evpage_in;
   fts_pkg::action_type            out_action_ff, out_action_in;

   logic [fts_pkg::COUNT_BITS-1:0] pool;
   logic [fts_pkg::COUNT_BITS-1:0] cur_inc;
   logic                           cur_last;
   logic [fts_pkg::CMP_BITS-1:0]   cmp_a, cmp_b;
   logic                           hit;
   fts_pkg::action_type            victim_action;
   logic [fts_pkg::FLAG_BITS-1:0]  new_flags;

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.status       = out_status_ff;
   assign rsp_ch.result_frame = fts_pkg::FNUM_BITS'(out_frame_ff);
   assign rsp_ch.evicted      = out_evicted_ff;
   assign rsp_ch.evicted_page = out_evpage_ff;
   assign rsp_ch.evict_action = out_action_ff;

   // shared cursor step and comparator
   assign pool     = (int'(user_frame_count) > fts_pkg::FRAMES) ?
                     fts_pkg::COUNT_BITS'(fts_pkg::FRAMES) :
                     fts_pkg::COUNT_BITS'(user_frame_count);
   assign cur_inc  = cur_ff + 1'b1;
   assign cur_last = (cur_inc >= view.count);
   assign hit      = (cmp_a == cmp_b);

   always_comb begin
      if (op_ff == fts_pkg::OP_FIND) begin
         cmp_a = fts_pkg::CMP_BITS'(view.page);
         cmp_b = fts_pkg::CMP_BITS'(page_ff);
      end else begin
         cmp_a = fts_pkg::CMP_BITS'(view.age_frame);
         cmp_b = fts_pkg::CMP_BITS'(fnum_ff);
      end
   end

   always_comb begin
      if (view.flags[fts_pkg::FLAG_DIRTY] || view.flags[fts_pkg::FLAG_SWAP]) begin
         victim_action = view.flags[fts_pkg::FLAG_MAP] ? fts_pkg::ACT_WRITEBACK :
                                                         fts_pkg::ACT_SWAP;
      end else begin
         victim_action = fts_pkg::ACT_DROP;
      end
   end

   always_comb begin
      new_flags                      = '0;
      new_flags[fts_pkg::FLAG_MAP]   = mapped_ff;
      new_flags[fts_pkg::FLAG_SWAP]  = swapped_ff;
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      page_in        = page_ff;
      fnum_in        = fnum_ff;
      mapped_in      = mapped_ff;
      swapped_in     = swapped_ff;
      write_in       = write_ff;
      cur_in         = cur_ff;
      res_status_in  = res_status_ff;
      res_frame_in   = res_frame_ff;
      res_evicted_in = res_evicted_ff;
      res_evpage_in  = res_evpage_ff;
      res_action_in  = res_action_ff;
      out_valid_in   = out_valid_ff;
      out_status_in  = out_status_ff;
      out_frame_in   = out_frame_ff;
      out_evicted_in = out_evicted_ff;
      out_evpage_in  = out_evpage_ff;
      out_action_in  = out_action_ff;

      cmd            = '0;
      cmd.pos        = cur_ff[fts_pkg::FRAME_BITS-1:0];
      cmd.frame      = view.age_frame;
      cmd.page       = page_ff;
      cmd.flags      = new_flags;
      cmd.mark_dirty = write_ff;

      if (rsp_ch.valid && rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in          = fts_pkg::op_type'(req_ch.op);
               page_in        = req_ch.page_id;
               fnum_in        = req_ch.frame_number;
               mapped_in      = req_ch.is_mapped_file;
               swapped_in     = req_ch.was_swapped;
               write_in       = req_ch.is_write;
               cur_in         = '0;
               res_status_in  = fts_pkg::ST_OK;
               res_frame_in   = '0;
               res_evicted_in = 1'b0;
               res_evpage_in  = '0;
               res_action_in  = fts_pkg::ACT_DROP;
               case (fts_pkg::op_type'(req_ch.op))
                  fts_pkg::OP_ALLOC: begin
                     state_in = S_POOL;
                  end
                  default: begin
                     if (view.count == '0) begin
                        res_status_in = fts_pkg::ST_NOT_FOUND;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_LIST;
                     end
                  end
               endcase
            end
         end
         S_POOL: begin
            cmd.frame = cur_ff[fts_pkg::FRAME_BITS-1:0];
            if (cur_ff >= pool) begin
               cur_in = '0;
               if (view.count == '0) begin
                  res_status_in = fts_pkg::ST_NO_FRAME;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_EVICT;
               end
            end else if (view.free) begin
               res_frame_in = cur_ff[fts_pkg::FRAME_BITS-1:0];
               state_in     = S_APPEND;
            end else begin
               cur_in = cur_inc;
            end
         end
         S_EVICT: begin
            if (view.flags[fts_pkg::FLAG_ACC]) begin
               cmd.clr_acc = 1'b1;
               cur_in      = cur_last ? '0 : cur_inc;
            end else begin
               cmd.remove     = 1'b1;
               res_frame_in   = view.age_frame;
               res_evicted_in = 1'b1;
               res_evpage_in  = view.page;
               res_action_in  = victim_action;
               state_in       = S_APPEND;
            end
         end
         S_LIST: begin
            if (hit) begin
               res_status_in = fts_pkg::ST_OK;
               case (op_ff)
                  fts_pkg::OP_FIND:  res_frame_in = view.age_frame;
                  fts_pkg::OP_FREE:  cmd.remove   = 1'b1;
                  fts_pkg::OP_TOUCH: cmd.mark     = 1'b1;
                  default:           res_frame_in = res_frame_ff;
               endcase
               state_in = S_DONE;
            end else if (cur_last) begin
               res_status_in = fts_pkg::ST_NOT_FOUND;
               state_in      = S_DONE;
            end else begin
               cur_in = cur_inc;
            end
         end
         S_APPEND: begin
            cmd.frame  = res_frame_ff;
            cmd.append = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!out_valid_ff || rsp_ch.ready) begin
               out_valid_in   = 1'b1;
               out_status_in  = res_status_ff;
               out_frame_in   = res_frame_ff;
               out_evicted_in = res_evicted_ff;
               out_evpage_in  = res_evpage_ff;
               out_action_in  = res_action_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      page_ff        <= page_in;
      fnum_ff        <= fnum_in;
      mapped_ff      <= mapped_in;
      swapped_ff     <= swapped_in;
      write_ff       <= write_in;
      cur_ff         <= cur_in;
      res_status_ff  <= res_status_in;
      res_frame_ff   <= res_frame_in;
      res_evicted_ff <= res_evicted_in;
      res_evpage_ff  <= res_evpage_in;
      res_action_ff  <= res_action_in;
      out_status_ff  <= out_status_in;
      out_frame_ff   <= out_frame_in;
      out_evicted_ff <= out_evicted_in;
      out_evpage_ff  <= out_evpage_in;
      out_action_ff  <= out_action_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      view.count <= fts_pkg::COUNT_BITS'(fts_pkg::FRAMES))
      else $error("resident count above frame total");

   a_evict_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EVICT |-> view.count != '0)
      else $error("eviction scan over empty age list");

   a_victim_append: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVICT && !view.flags[fts_pkg::FLAG_ACC])
      |=> (state_ff == S_APPEND && res_evicted_ff))
      else $error("victim found but no append of new page");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> state_ff != S_IDLE)
      else $error("transaction accepted but sequencer idle");

   a_no_frame_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_status_ff == fts_pkg::ST_NO_FRAME) |-> !out_evicted_ff)
      else $error("no-frame response reports an eviction");

endmodule
